// ===== design/poisson_sample_acceptance_defines.svh =====
// Assertion macros for the Poisson sample acceptance block.
// Depends on clk_i and rst_ni being visible where the macros are used.
`ifndef POISSON_SAMPLE_ACCEPTANCE_DEFINES_SVH
`define POISSON_SAMPLE_ACCEPTANCE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define PSA_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("psa assertion failed");

// Next-cycle implication, disabled during reset.
`define PSA_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("psa assertion failed");

`endif

// ===== design/psa_pkg.sv =====
// Shared types and constants of the Poisson sample acceptance block.
// No dependencies; used by psa_divider and poisson_sample_acceptance.
package psa_pkg;

  localparam int EDGE_MAX = 256;
  localparam int EDGE_AW  = $clog2(EDGE_MAX);
  localparam int EDGE_CW  = $clog2(EDGE_MAX + 1);
  localparam int GRID_DIM = 64;
  localparam int GRID_AW  = $clog2(GRID_DIM);
  localparam int CELL_AW  = 2 * GRID_AW;
  localparam int CELL_W   = 34;

  typedef enum logic [1:0] {
    FUNC_OUTER, FUNC_INNER, FUNC_STORE, FUNC_TEST
  } func_e;

  typedef enum logic [2:0] {
    ST_OK, ST_OUTSIDE, ST_HOLE, ST_CLOSE, ST_FULL, ST_OFFGRID
  } status_e;

  localparam logic [2:0] CFG_CELL_SIZE = 3'd0;
  localparam logic [2:0] CFG_MIN_DIST  = 3'd1;
  localparam logic [2:0] CFG_RAY_X     = 3'd2;
  localparam logic [2:0] CFG_COLS      = 3'd3;
  localparam logic [2:0] CFG_ROWS      = 3'd4;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_EXEC, S_DIVX, S_DIVY, S_STORE, S_OUTER, S_INNER, S_GRID, S_DONE
  } state_e;

  typedef struct packed {
    logic                     done;
    logic signed [CELL_W-1:0] quo;
  } div_res_t;

endpackage

// ===== design/psa_divider.sv =====
// Radix-2 restoring divider giving the floor of a signed coordinate over the cell size.
// Depends on psa_pkg for the result struct.
module psa_divider (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic signed [31:0]  dividend_i,
  input  logic        [30:0]  divisor_i,
  output psa_pkg::div_res_t   res_o
);

  logic        busy_q, done_q, neg_q;
  logic [4:0]  cnt_q;
  logic [31:0] num_q, rem_q, quo_q;
  logic [30:0] div_q;
  logic [32:0] trial;
  logic        fits;
  logic [32:0] q_up;

  // One quotient bit per cycle.
  assign trial = {rem_q, num_q[31]};
  assign fits  = trial >= {2'b00, div_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 5'd1;
        if (cnt_q == 5'd31) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q <= dividend_i[31];
      num_q <= dividend_i[31] ? 32'(-dividend_i) : dividend_i;
      div_q <= (divisor_i == '0) ? 31'd1 : divisor_i;
      rem_q <= '0;
      quo_q <= '0;
    end else if (busy_q) begin
      num_q <= {num_q[30:0], 1'b0};
      rem_q <= fits ? 32'(trial - {2'b00, div_q}) : trial[31:0];
      quo_q <= {quo_q[30:0], fits};
    end
  end

  // Negative dividends round toward minus infinity.
  assign q_up = {1'b0, quo_q} + {32'd0, (neg_q && rem_q != '0)};
  assign res_o.done = done_q;
  assign res_o.quo  = neg_q ? -$signed({1'b0, q_up}) : $signed({1'b0, q_up});

endmodule

// ===== design/poisson_sample_acceptance.sv =====
// Top level of the Poisson sample acceptance block: edge tables, grid store, test sequencer.
// Depends on psa_pkg, psa_divider and poisson_sample_acceptance_defines.svh.
//
//  channel   | direction | handshake                  | payload
//  s_axis    | in        | s_axis_tvalid/s_axis_tready | tdata px,py,end_x,end_y; tuser func
//  m_axis    | out       | m_axis_tvalid/m_axis_tready | tdata status,accepted,col,row
//  cfg       | in        | cfg_valid_i/cfg_ready_o     | cfg_index_i, cfg_data_i
//
// One item at a time. Edge loads append to a table; stores run two divides, x then y. A test
// runs both divides, then the outer edge, inner edge and grid scans (at most 9 cells), each
// doing one read per cycle with a 3-stage drain; a failed edge scan ends the test early.
// After reset a clearing pass walks all 4096 grid cells, one per cycle, before items are taken.
// A result waits in the output register while the next item is already accepted.
`include "poisson_sample_acceptance_defines.svh"

module poisson_sample_acceptance (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [127:0] s_axis_tdata,  // px[31:0], py[63:32], end_x[95:64], end_y[127:96]
  input  logic [1:0]   s_axis_tuser,  // func[1:0]
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [39:0]  m_axis_tdata,  // status[2:0], accepted[3], cell_col[19:4],
                                      // cell_row[35:20], zero[39:36]
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [2:0]   cfg_index_i,
  input  logic [31:0]  cfg_data_i
);

  localparam int W = psa_pkg::CELL_W;

  psa_pkg::state_e state_q, state_d;

  logic [30:0]        cell_size_q, min_dist_q;
  logic signed [31:0] ray_x_q;
  logic [6:0]         cols_q, rows_q;
  logic [61:0]        lim_q;

  psa_pkg::func_e     func_q;
  logic signed [31:0] px_q, py_q, ex_q, ey_q;
  logic [psa_pkg::EDGE_CW-1:0] outer_cnt_q, inner_cnt_q, idx_q, cur_cnt;
  logic signed [W-1:0] col_q, row_q;
  psa_pkg::status_e   status_q;
  logic               acc_q;

  logic [psa_pkg::GRID_AW-1:0] gc_q, gr_q, gc0_q, gc1_q, gr0_q, gr1_q;
  logic               issued_q;
  logic               v1_q, v2_q, v3_q, parity_q, close_q;
  logic [psa_pkg::CELL_AW-1:0] clr_q;

  logic [127:0] edge_mem [2*psa_pkg::EDGE_MAX];
  logic [127:0] edge_rd_q;
  logic [64:0]  grid_mem [psa_pkg::GRID_DIM*psa_pkg::GRID_DIM];
  logic [64:0]  grid_rd_q;

  logic         m_valid_q;
  logic [35:0]  m_data_q;

  // Control signals.
  logic in_take, issue, pipe_empty, scan_end, edge_done, out_load, div_start;
  logic edge_we, grid_we, edge_full;
  logic [psa_pkg::EDGE_AW:0]   edge_wa, edge_ra;
  logic [psa_pkg::CELL_AW-1:0] grid_wa;
  logic [64:0]  grid_wd;
  logic signed [31:0] div_a;
  psa_pkg::div_res_t  div_res;

  // Grid bounds.
  logic signed [W-1:0] ncols, nrows, c0, c1, r0, r1;
  logic nb_empty, off_grid;

  psa_divider u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_a),
    .divisor_i  (cell_size_q),
    .res_o      (div_res)
  );

  function automatic logic [15:0] sat16(input logic signed [W-1:0] v);
    logic [15:0] r;
    if (v > W'(32767)) r = 16'h7fff;
    else if (v < -W'(32768)) r = 16'h8000;
    else r = v[15:0];
    return r;
  endfunction

  // Grid extent and clamped neighborhood.
  always_comb begin
    ncols = (cols_q > 7'(psa_pkg::GRID_DIM)) ? W'(psa_pkg::GRID_DIM) : W'(cols_q);
    nrows = (rows_q > 7'(psa_pkg::GRID_DIM)) ? W'(psa_pkg::GRID_DIM) : W'(rows_q);
    c0 = (col_q - W'(1) < 0) ? '0 : col_q - W'(1);
    c1 = (col_q + W'(1) > ncols - W'(1)) ? ncols - W'(1) : col_q + W'(1);
    r0 = (row_q - W'(1) < 0) ? '0 : row_q - W'(1);
    r1 = (row_q + W'(1) > nrows - W'(1)) ? nrows - W'(1) : row_q + W'(1);
    nb_empty = (c0 > c1) || (r0 > r1);
    off_grid = (col_q < 0) || (row_q < 0) || (col_q >= ncols) || (row_q >= nrows);
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      psa_pkg::S_CLEAR: if (&clr_q) state_d = psa_pkg::S_IDLE;
      psa_pkg::S_IDLE:  if (in_take) state_d = psa_pkg::S_EXEC;
      psa_pkg::S_EXEC: begin
        if (func_q == psa_pkg::FUNC_OUTER || func_q == psa_pkg::FUNC_INNER) begin
          state_d = psa_pkg::S_DONE;
        end else begin
          state_d = psa_pkg::S_DIVX;
        end
      end
      psa_pkg::S_DIVX: if (div_res.done) state_d = psa_pkg::S_DIVY;
      psa_pkg::S_DIVY: begin
        if (div_res.done) begin
          state_d = (func_q == psa_pkg::FUNC_STORE) ? psa_pkg::S_STORE : psa_pkg::S_OUTER;
        end
      end
      psa_pkg::S_STORE: state_d = psa_pkg::S_DONE;
      psa_pkg::S_OUTER: if (scan_end) state_d = parity_q ? psa_pkg::S_INNER : psa_pkg::S_DONE;
      psa_pkg::S_INNER: if (scan_end) state_d = parity_q ? psa_pkg::S_DONE : psa_pkg::S_GRID;
      psa_pkg::S_GRID:  if (scan_end) state_d = psa_pkg::S_DONE;
      psa_pkg::S_DONE:  if (out_load) state_d = psa_pkg::S_IDLE;
      default: state_d = psa_pkg::S_IDLE;
    endcase
  end

  // Control outputs.
  always_comb begin
    s_axis_tready = (state_q == psa_pkg::S_IDLE);
    cfg_ready_o   = 1'b1;
    in_take       = s_axis_tvalid && s_axis_tready;
    cur_cnt       = (state_q == psa_pkg::S_INNER) ? inner_cnt_q : outer_cnt_q;
    edge_done     = (idx_q == cur_cnt);
    pipe_empty    = !v1_q && !v2_q && !v3_q;
    issue         = 1'b0;
    scan_end      = 1'b0;
    unique case (state_q)
      psa_pkg::S_OUTER, psa_pkg::S_INNER: begin
        issue    = !edge_done;
        scan_end = edge_done && pipe_empty;
      end
      psa_pkg::S_GRID: begin
        issue    = !issued_q;
        scan_end = issued_q && pipe_empty;
      end
      default: ;
    endcase
    edge_ra   = {(state_q == psa_pkg::S_INNER), idx_q[psa_pkg::EDGE_AW-1:0]};
    edge_full = (func_q == psa_pkg::FUNC_INNER) ? inner_cnt_q[psa_pkg::EDGE_AW]
                                                : outer_cnt_q[psa_pkg::EDGE_AW];
    edge_wa   = (func_q == psa_pkg::FUNC_INNER)
              ? {1'b1, inner_cnt_q[psa_pkg::EDGE_AW-1:0]}
              : {1'b0, outer_cnt_q[psa_pkg::EDGE_AW-1:0]};
    edge_we   = (state_q == psa_pkg::S_EXEC) && !edge_full &&
                (func_q == psa_pkg::FUNC_OUTER || func_q == psa_pkg::FUNC_INNER);
    grid_we   = (state_q == psa_pkg::S_CLEAR) || ((state_q == psa_pkg::S_STORE) && !off_grid);
    grid_wa   = (state_q == psa_pkg::S_CLEAR) ? clr_q
              : {row_q[psa_pkg::GRID_AW-1:0], col_q[psa_pkg::GRID_AW-1:0]};
    grid_wd   = (state_q == psa_pkg::S_CLEAR) ? '0 : {1'b1, py_q, px_q};
    div_start = ((state_q == psa_pkg::S_EXEC) &&
                 (func_q == psa_pkg::FUNC_STORE || func_q == psa_pkg::FUNC_TEST)) ||
                ((state_q == psa_pkg::S_DIVX) && div_res.done);
    div_a     = (state_q == psa_pkg::S_EXEC) ? px_q : py_q;
    out_load  = (state_q == psa_pkg::S_DONE) && (!m_valid_q || m_axis_tready);
  end

  // Memories: one write and one registered read per cycle each.
  always_ff @(posedge clk_i) begin
    if (edge_we) edge_mem[edge_wa] <= {ey_q, ex_q, py_q, px_q};
    edge_rd_q <= edge_mem[edge_ra];
  end

  always_ff @(posedge clk_i) begin
    if (grid_we) grid_mem[grid_wa] <= grid_wd;
    grid_rd_q <= grid_mem[{gr_q, gc_q}];
  end

  // Edge crossing pipeline, stage one: ordering, range and differences.
  logic signed [31:0] x1, y1, x2, y2, xa, ya, xb, yb, lo_x, hi_x;
  logic signed [32:0] e_a, e_dx, e_dy, e_dl, e_dh;
  logic               e_horiz, e_hcross, e_inr;
  always_comb begin
    x1 = edge_rd_q[31:0];
    y1 = edge_rd_q[63:32];
    x2 = edge_rd_q[95:64];
    y2 = edge_rd_q[127:96];
    lo_x = (px_q < ray_x_q) ? px_q : ray_x_q;
    hi_x = (px_q < ray_x_q) ? ray_x_q : px_q;
    xa = (y1 > y2) ? x2 : x1;
    ya = (y1 > y2) ? y2 : y1;
    xb = (y1 > y2) ? x1 : x2;
    yb = (y1 > y2) ? y1 : y2;
    e_horiz  = (y1 == y2);
    e_hcross = (x1 == x2) && (py_q == y1) && (x1 >= lo_x) && (x1 <= hi_x);
    e_inr    = (py_q >= ya) && (py_q <= yb);
    e_a  = 33'(py_q) - 33'(ya);
    e_dx = 33'(xb) - 33'(xa);
    e_dy = 33'(yb) - 33'(ya);
    e_dl = 33'(xa) - 33'(lo_x);
    e_dh = 33'(xa) - 33'(hi_x);
  end

  // Grid distance pipeline, stage one: offsets and far check.
  logic signed [31:0] gx, gy;
  logic signed [32:0] g_dx, g_dy;
  logic [32:0]        g_ax, g_ay;
  always_comb begin
    gx   = grid_rd_q[31:0];
    gy   = grid_rd_q[63:32];
    g_dx = 33'(gx) - 33'(px_q);
    g_dy = 33'(gy) - 33'(py_q);
    g_ax = g_dx[32] ? 33'(-g_dx) : 33'(g_dx);
    g_ay = g_dy[32] ? 33'(-g_dy) : 33'(g_dy);
  end

  logic signed [32:0] s2_a, s2_dx, s2_dy, s2_dl, s2_dh;
  logic               s2_horiz, s2_hcross, s2_inr, s2_ok;
  logic [30:0]        s2_ax, s2_ay;
  logic signed [65:0] s3_m1, s3_m2, s3_m3;
  logic               s3_horiz, s3_hcross, s3_inr, s3_ok;
  logic [61:0]        s3_sx, s3_sy;
  logic signed [66:0] t_sum, u_sum;
  logic               edge_hit, near;

  // Stage two registers the differences, stage three the products.
  always_ff @(posedge clk_i) begin
    s2_a <= e_a;
    s2_dx <= e_dx;
    s2_dy <= e_dy;
    s2_dl <= e_dl;
    s2_dh <= e_dh;
    s2_horiz <= e_horiz;
    s2_hcross <= e_hcross;
    s2_inr <= e_inr;
    s2_ok <= grid_rd_q[64] && !g_ax[32] && !g_ax[31] && !g_ay[32] && !g_ay[31];
    s2_ax <= g_ax[30:0];
    s2_ay <= g_ay[30:0];
    s3_m1 <= s2_a * s2_dx;
    s3_m2 <= s2_dl * s2_dy;
    s3_m3 <= s2_dh * s2_dy;
    s3_horiz <= s2_horiz;
    s3_hcross <= s2_hcross;
    s3_inr <= s2_inr;
    s3_ok <= s2_ok;
    s3_sx <= s2_ax * s2_ax;
    s3_sy <= s2_ay * s2_ay;
    lim_q <= min_dist_q * min_dist_q;
  end

  // Final compare of each edge and each cell.
  always_comb begin
    t_sum = 67'(s3_m1) + 67'(s3_m2);
    u_sum = 67'(s3_m1) + 67'(s3_m3);
    edge_hit = s3_horiz ? s3_hcross
                        : (s3_inr && !t_sum[66] && (u_sum[66] || u_sum == '0));
    near  = s3_ok && ({1'b0, s3_sx} + {1'b0, s3_sy} < {1'b0, lim_q});
  end

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_size_q <= 31'd65536;
      min_dist_q  <= 31'd65536;
      ray_x_q     <= -32'sd65536;
      cols_q      <= 7'd64;
      rows_q      <= 7'd64;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        psa_pkg::CFG_CELL_SIZE: cell_size_q <= cfg_data_i[30:0];
        psa_pkg::CFG_MIN_DIST:  min_dist_q  <= cfg_data_i[30:0];
        psa_pkg::CFG_RAY_X:     ray_x_q     <= cfg_data_i;
        psa_pkg::CFG_COLS:      cols_q      <= cfg_data_i[6:0];
        psa_pkg::CFG_ROWS:      rows_q      <= cfg_data_i[6:0];
        default: ;
      endcase
    end
  end

  // Item payload.
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      func_q <= psa_pkg::func_e'(s_axis_tuser);
      px_q   <= s_axis_tdata[31:0];
      py_q   <= s_axis_tdata[63:32];
      ex_q   <= s_axis_tdata[95:64];
      ey_q   <= s_axis_tdata[127:96];
    end
  end

  // Sequencer state, counters and scan control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= psa_pkg::S_CLEAR;
      clr_q       <= '0;
      outer_cnt_q <= '0;
      inner_cnt_q <= '0;
      idx_q       <= '0;
      parity_q    <= 1'b0;
      close_q     <= 1'b0;
      issued_q    <= 1'b1;
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      status_q    <= psa_pkg::ST_OK;
      acc_q       <= 1'b0;
      col_q       <= '0;
      row_q       <= '0;
      gc_q        <= '0;
      gr_q        <= '0;
      gc0_q       <= '0;
      gc1_q       <= '0;
      gr0_q       <= '0;
      gr1_q       <= '0;
      m_valid_q   <= 1'b0;
      m_data_q    <= '0;
    end else begin
      state_q <= state_d;
      v1_q <= issue;
      v2_q <= v1_q;
      v3_q <= v2_q;
      if (state_q == psa_pkg::S_CLEAR) clr_q <= clr_q + 1'b1;

      if (in_take) begin
        status_q <= psa_pkg::ST_OK;
        acc_q    <= 1'b0;
        col_q    <= '0;
        row_q    <= '0;
      end

      if (state_q == psa_pkg::S_EXEC && !div_start) begin
        if (edge_full) begin
          status_q <= psa_pkg::ST_FULL;
        end else if (func_q == psa_pkg::FUNC_INNER) begin
          inner_cnt_q <= inner_cnt_q + 1'b1;
        end else begin
          outer_cnt_q <= outer_cnt_q + 1'b1;
        end
      end

      if (state_q == psa_pkg::S_DIVX && div_res.done) col_q <= div_res.quo;
      if (state_q == psa_pkg::S_DIVY && div_res.done) row_q <= div_res.quo;
      if (state_q == psa_pkg::S_STORE && off_grid) status_q <= psa_pkg::ST_OFFGRID;

      // Edge scans: one edge read per cycle, parity from the last stage.
      if (state_q != state_d) begin
        idx_q    <= '0;
        parity_q <= 1'b0;
      end else begin
        if (issue) idx_q <= idx_q + 1'b1;
        if (v3_q && edge_hit) parity_q <= !parity_q;
      end

      if (state_q == psa_pkg::S_OUTER && scan_end && !parity_q) status_q <= psa_pkg::ST_OUTSIDE;
      if (state_q == psa_pkg::S_INNER && scan_end && parity_q) status_q <= psa_pkg::ST_HOLE;

      // Grid scan setup over the clamped neighborhood.
      if (state_q == psa_pkg::S_INNER && state_d == psa_pkg::S_GRID) begin
        gc0_q    <= c0[psa_pkg::GRID_AW-1:0];
        gc1_q    <= c1[psa_pkg::GRID_AW-1:0];
        gr0_q    <= r0[psa_pkg::GRID_AW-1:0];
        gr1_q    <= r1[psa_pkg::GRID_AW-1:0];
        gc_q     <= c0[psa_pkg::GRID_AW-1:0];
        gr_q     <= r0[psa_pkg::GRID_AW-1:0];
        issued_q <= nb_empty;
        close_q  <= 1'b0;
      end else if (state_q == psa_pkg::S_GRID) begin
        if (issue) begin
          if (gr_q == gr1_q) begin
            gr_q <= gr0_q;
            if (gc_q == gc1_q) issued_q <= 1'b1;
            else gc_q <= gc_q + 1'b1;
          end else begin
            gr_q <= gr_q + 1'b1;
          end
        end
        if (v3_q && near) close_q <= 1'b1;
        if (scan_end) begin
          if (close_q) status_q <= psa_pkg::ST_CLOSE;
          else acc_q <= 1'b1;
        end
      end

      // Output register.
      if (out_load) begin
        m_valid_q <= 1'b1;
        m_data_q  <= {sat16(row_q), sat16(col_q), acc_q, status_q};
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {4'b0000, m_data_q};

  `PSA_ASSERT_IMP(a_ready_idle, s_axis_tready, state_q == psa_pkg::S_IDLE)
  `PSA_ASSERT_IMP(a_cnt_bound, 1'b1, outer_cnt_q <= psa_pkg::EDGE_CW'(psa_pkg::EDGE_MAX) && inner_cnt_q <= psa_pkg::EDGE_CW'(psa_pkg::EDGE_MAX))
  `PSA_ASSERT_IMP(a_div_state, div_res.done, state_q == psa_pkg::S_DIVX || state_q == psa_pkg::S_DIVY)
  `PSA_ASSERT_NXT(a_issue_scan, issue, state_q == psa_pkg::S_OUTER || state_q == psa_pkg::S_INNER || state_q == psa_pkg::S_GRID || v1_q)

endmodule
